// ----- hdl/kmp_pkg.sv -----
// ============================================================================
// kmp_pkg - shared types and constants of the keyboard macro player
// Item kinds, action codes, queue and report types, modifier decode.
// ============================================================================
package kmp_pkg;

    // Default sizes handed to the top level
    localparam int DEF_SLOT_COUNT       = 5;
    localparam int DEF_ACTIONS_PER_SLOT = 64;
    localparam int DEF_REPORT_KEYS      = 6;

    // Fixed report layout and queue size
    localparam int MAX_KEYS    = 6;
    localparam int QUEUE_DEPTH = 4;

    // Delay unit after reset, in ms
    localparam logic [15:0] DELAY_UNIT_RESET = 16'd100;

    // Slot code meaning no macro active
    localparam logic [2:0] NO_SLOT = 3'd7;

    // Item kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_RESUME = 2'd2;
    localparam logic [1:0] KIND_STEP   = 2'd3;

    // Action codes
    localparam logic [7:0] ACT_END   = 8'd0;
    localparam logic [7:0] ACT_DOWN  = 8'd1;
    localparam logic [7:0] ACT_UP    = 8'd2;
    localparam logic [7:0] ACT_PRESS = 8'd3;
    localparam logic [7:0] ACT_DELAY = 8'd4;
    localparam logic [7:0] ACT_PAUSE = 8'd5;

    // Empty key usage and empty modifier byte
    localparam logic [7:0] KEY_NONE = 8'h00;

    // Command passed from the front end to the executor
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  slot;
        logic [5:0]  position;
        logic [7:0]  code;
        logic [7:0]  value;
        logic [31:0] now_ms;
    } t_cmd;

    // One keyboard report
    typedef struct packed {
        logic [7:0]                modifier_bits;
        logic [MAX_KEYS-1:0][7:0] keys;
        logic                      running;
    } t_report;

    // Modifier bit for the left ctrl, shift, alt and gui usages
    function automatic logic [7:0] modifier_of(input logic [7:0] key);
        logic [7:0] bits;
        bits = 8'h00;
        if (key[7:2] == 6'b111000) begin
            bits = 8'h01 << key[1:0];
        end
        return bits;
    endfunction

endpackage

// ----- hdl/kmp_if.sv -----
// ============================================================================
// kmp_if - item and report channels of the keyboard macro player
// Valid/ready channels carrying one input item or one report.
// ============================================================================
interface kmp_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic [5:0]  position;
    logic [7:0]  action_code;
    logic [7:0]  action_value;
    logic [31:0] now_ms;

    modport source (
        output valid, kind, slot, position, action_code, action_value, now_ms,
        input  ready
    );
    modport sink (
        input  valid, kind, slot, position, action_code, action_value, now_ms,
        output ready
    );
endinterface

interface kmp_report_if;
    logic       valid;
    logic       ready;
    logic [7:0] modifier_bits;
    logic [7:0] key_a;
    logic [7:0] key_b;
    logic [7:0] key_c;
    logic [7:0] key_d;
    logic [7:0] key_e;
    logic [7:0] key_f;
    logic       running;

    modport source (
        output valid, modifier_bits, key_a, key_b, key_c, key_d, key_e, key_f,
               running,
        input  ready
    );
    modport sink (
        input  valid, modifier_bits, key_a, key_b, key_c, key_d, key_e, key_f,
               running,
        output ready
    );
endinterface

// ----- hdl/kmp_front.sv -----
// ============================================================================
// kmp_front - item intake and classification
// Accepts items, drops loads and slot commands that can never apply.
// ============================================================================
module kmp_front #(
    parameter int SLOT_COUNT       = 5,
    parameter int ACTIONS_PER_SLOT = 64
) (
    kmp_item_if.sink       i_item,
    input  logic           i_full,
    output logic           o_push,
    output kmp_pkg::t_cmd  o_cmd
);
    import kmp_pkg::*;

    logic slot_ok;
    logic pos_ok;
    logic keep;

    // Accept whenever the queue has room
    assign i_item.ready = !i_full;

    assign slot_ok = (int'(i_item.slot) < SLOT_COUNT) && (i_item.slot != NO_SLOT);
    assign pos_ok  = int'(i_item.position) < ACTIONS_PER_SLOT;

    // Classify: keep only items the executor has to see
    always_comb begin
        unique case (i_item.kind)
            KIND_LOAD:                keep = slot_ok && pos_ok;
            KIND_START, KIND_RESUME:  keep = slot_ok;
            default:                  keep = 1'b1;
        endcase
    end

    assign o_push = i_item.valid && !i_full && keep;

    assign o_cmd.kind     = i_item.kind;
    assign o_cmd.slot     = i_item.slot;
    assign o_cmd.position = i_item.position;
    assign o_cmd.code     = i_item.action_code;
    assign o_cmd.value    = i_item.action_value;
    assign o_cmd.now_ms   = i_item.now_ms;

endmodule

// ----- hdl/kmp_fifo.sv -----
// ============================================================================
// kmp_fifo - command queue between front end and executor
// Small synchronous queue of commands.
// ============================================================================
module kmp_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  kmp_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output kmp_pkg::t_cmd  o_cmd
);
    import kmp_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- hdl/kmp_back.sv -----
// ============================================================================
// kmp_back - macro executor
// Holds the action store and player state, runs at most one action per command.
// ============================================================================
module kmp_back #(
    parameter int SLOT_COUNT       = 5,
    parameter int ACTIONS_PER_SLOT = 64,
    parameter int REPORT_KEYS      = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [15:0]       i_cfg_wr_data,
    input  logic              i_cmd_valid,
    input  kmp_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    output logic              o_res_valid,
    output kmp_pkg::t_report  o_res,
    input  logic              i_res_ready
);
    import kmp_pkg::*;

    localparam int STORE_DEPTH = SLOT_COUNT * ACTIONS_PER_SLOT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PC_W        = $clog2(ACTIONS_PER_SLOT + 1);
    localparam int CNT_W       = $clog2(REPORT_KEYS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // Action store: code in the upper byte, value in the lower
    logic [15:0]      r_store [STORE_DEPTH];
    logic [15:0]      r_rd_data;

    logic             r_state;
    logic [2:0]       r_active;
    logic [PC_W-1:0]  r_slot_pos [SLOT_COUNT];
    logic [7:0]       r_keys [REPORT_KEYS];
    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_mod;
    logic             r_half;
    logic             r_delay_run;
    logic [31:0]      r_delay_begin;
    logic [15:0]      r_unit;

    logic [2:0]       r_ex_slot;
    logic [PC_W-1:0]  r_ex_pos;
    logic [31:0]      r_ex_now;
    logic             r_ex_exh;

    logic             r_res_valid;
    t_report          r_res;

    // Dispatch side
    logic [2:0]       cur_slot;
    logic [PC_W-1:0]  sel_pos;
    logic [PC_W-1:0]  disp_pos;
    logic             disp_exh;
    logic             go;
    logic             wr_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    // Execute side
    logic             fire;
    logic [7:0]       code;
    logic [7:0]       value;
    logic             adv;
    logic             do_down;
    logic             do_up;
    logic [REPORT_KEYS-1:0] hit;
    logic             any_hit;
    logic [7:0]       last_key;
    logic [31:0]      elapsed;
    logic [23:0]      limit;
    logic [7:0]       n_keys [REPORT_KEYS];
    logic [CNT_W-1:0] n_count;
    logic [7:0]       n_mod;
    logic             n_half;
    logic             n_delay_run;
    logic [31:0]      n_delay_begin;
    logic [PC_W-1:0]  n_pos;
    logic [2:0]       n_active;
    t_report          n_res;

    // Pick the slot and entry of the next command
    always_comb begin
        cur_slot = (i_cmd.kind == KIND_STEP) ? r_active : i_cmd.slot;
        sel_pos  = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (cur_slot == 3'(i)) begin
                sel_pos = r_slot_pos[i];
            end
        end
        disp_pos = (i_cmd.kind == KIND_START) ? '0 : sel_pos;
        disp_exh = (disp_pos >= PC_W'(ACTIONS_PER_SLOT));
        rd_addr  = ADDR_W'(int'(cur_slot) * ACTIONS_PER_SLOT + int'(disp_pos));
        wr_addr  = ADDR_W'(int'(i_cmd.slot) * ACTIONS_PER_SLOT + int'(i_cmd.position));
    end

    assign o_cmd_pop = i_cmd_valid && (r_state == ST_IDLE);
    assign wr_en     = o_cmd_pop && (i_cmd.kind == KIND_LOAD);
    assign go        = o_cmd_pop &&
                       (((i_cmd.kind == KIND_STEP) && (r_active != NO_SLOT)) ||
                        (((i_cmd.kind == KIND_START) || (i_cmd.kind == KIND_RESUME)) &&
                         (r_active == NO_SLOT)));

    // Execute waits until the report register can take a new report
    assign fire  = (r_state == ST_EXEC) && (!r_res_valid || i_res_ready);
    assign code  = r_rd_data[15:8];
    assign value = r_rd_data[7:0];

    assign elapsed = r_ex_now - r_delay_begin;
    assign limit   = {16'h0000, value} * {8'h00, r_unit};

    // Decode the action
    always_comb begin
        adv           = 1'b0;
        do_down       = 1'b0;
        do_up         = 1'b0;
        n_half        = r_half;
        n_delay_run   = r_delay_run;
        n_delay_begin = r_delay_begin;
        if (!r_ex_exh) begin
            unique case (code)
                ACT_DOWN: begin
                    do_down = 1'b1;
                    adv     = 1'b1;
                end
                ACT_UP: begin
                    do_up = 1'b1;
                    adv   = 1'b1;
                end
                ACT_PRESS: begin
                    if (r_half) begin
                        do_up  = 1'b1;
                        n_half = 1'b0;
                        adv    = 1'b1;
                    end else begin
                        do_down = 1'b1;
                        n_half  = 1'b1;
                    end
                end
                ACT_DELAY: begin
                    if (!r_delay_run) begin
                        n_delay_run   = 1'b1;
                        n_delay_begin = r_ex_now;
                    end else if (elapsed > {8'h00, limit}) begin
                        n_delay_run = 1'b0;
                        adv         = 1'b1;
                    end
                end
                default: begin
                    adv = 1'b1;
                end
            endcase
        end
    end

    // Update the pressed-key set; removal moves the last key into the gap
    always_comb begin
        any_hit  = 1'b0;
        last_key = KEY_NONE;
        for (int i = 0; i < REPORT_KEYS; i++) begin
            hit[i] = (CNT_W'(i) < r_count) && (r_keys[i] == value);
            if (CNT_W'(i) == r_count - 1'b1) begin
                last_key = r_keys[i];
            end
        end
        any_hit = |hit;
        n_keys  = r_keys;
        n_count = r_count;
        n_mod   = r_mod;
        if (do_down) begin
            if ((value != KEY_NONE) && !any_hit && (r_count < CNT_W'(REPORT_KEYS))) begin
                for (int i = 0; i < REPORT_KEYS; i++) begin
                    if (CNT_W'(i) == r_count) begin
                        n_keys[i] = value;
                    end
                end
                n_count = r_count + 1'b1;
            end
            n_mod = r_mod | modifier_of(value);
        end
        if (do_up) begin
            if ((value != KEY_NONE) && any_hit) begin
                for (int i = 0; i < REPORT_KEYS; i++) begin
                    if (CNT_W'(i) == r_count - 1'b1) begin
                        n_keys[i] = KEY_NONE;
                    end else if (hit[i]) begin
                        n_keys[i] = last_key;
                    end
                end
                n_count = r_count - 1'b1;
            end
            n_mod = r_mod & ~modifier_of(value);
        end
    end

    // Advance position, decide whether the macro stays active, form report
    always_comb begin
        n_pos = r_ex_pos + PC_W'(adv);
        if (r_ex_exh || (code == ACT_END) || (code == ACT_PAUSE) ||
            (n_pos >= PC_W'(ACTIONS_PER_SLOT))) begin
            n_active = NO_SLOT;
        end else begin
            n_active = r_ex_slot;
        end
        n_res.modifier_bits = n_mod;
        for (int i = 0; i < MAX_KEYS; i++) begin
            n_res.keys[i] = KEY_NONE;
            if (i < REPORT_KEYS) begin
                n_res.keys[i] = n_keys[i];
            end
        end
        n_res.running = (n_active != NO_SLOT);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_active      <= NO_SLOT;
            r_count       <= '0;
            r_mod         <= 8'h00;
            r_half        <= 1'b0;
            r_delay_run   <= 1'b0;
            r_delay_begin <= '0;
            r_unit        <= DELAY_UNIT_RESET;
            r_res_valid   <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot_pos[i] <= '0;
            end
            for (int i = 0; i < REPORT_KEYS; i++) begin
                r_keys[i] <= KEY_NONE;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_unit <= i_cfg_wr_data;
            end
            if (fire) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (go) begin
                        r_state  <= ST_EXEC;
                        r_active <= cur_slot;
                        if (i_cmd.kind == KIND_START) begin
                            for (int i = 0; i < SLOT_COUNT; i++) begin
                                if (cur_slot == 3'(i)) begin
                                    r_slot_pos[i] <= '0;
                                end
                            end
                        end
                    end
                end
                ST_EXEC: begin
                    if (fire) begin
                        r_state       <= ST_IDLE;
                        r_active      <= n_active;
                        r_count       <= n_count;
                        r_mod         <= n_mod;
                        r_half        <= n_half;
                        r_delay_run   <= n_delay_run;
                        r_delay_begin <= n_delay_begin;
                        r_keys        <= n_keys;
                        for (int i = 0; i < SLOT_COUNT; i++) begin
                            if (!r_ex_exh && (r_ex_slot == 3'(i))) begin
                                r_slot_pos[i] <= n_pos;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Store write, entry read and execute context
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= {i_cmd.code, i_cmd.value};
        end
        if (go && !disp_exh) begin
            r_rd_data <= r_store[rd_addr];
        end
        if (go) begin
            r_ex_slot <= cur_slot;
            r_ex_pos  <= disp_pos;
            r_ex_now  <= i_cmd.now_ms;
            r_ex_exh  <= disp_exh;
        end
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Key count never exceeds the report size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(REPORT_KEYS))
        else $error("pressed key count exceeds report size");

    // A new report only comes from an executed action
    a_report_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res_valid) |-> $past(r_state) == ST_EXEC)
        else $error("report raised without an executed action");

    // A macro is active throughout execution
    a_exec_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> (r_active != NO_SLOT) && (r_active == r_ex_slot))
        else $error("executing without an active slot");

endmodule

// ----- hdl/keyboard_macro_player_unit.sv -----
// ============================================================================
// keyboard_macro_player_unit - keyboard macro player, top level
// Front end, command queue and macro executor.
// ============================================================================
// Items are taken one per clock, while the queue has room, into a four-entry
// command queue. The executor drains it: a load, or an item that does nothing,
// is retired when popped; a start, resume or step reads the action store, then
// updates the state and forms its report, popping nothing meanwhile. Its report
// sits in an output register, so the next command is read while it waits.
module keyboard_macro_player_unit #(
    parameter int SLOT_COUNT       = kmp_pkg::DEF_SLOT_COUNT,
    parameter int ACTIONS_PER_SLOT = kmp_pkg::DEF_ACTIONS_PER_SLOT,
    parameter int REPORT_KEYS      = kmp_pkg::DEF_REPORT_KEYS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic [15:0]    i_cfg_wr_data,
    kmp_item_if.sink       i_item,
    kmp_report_if.source   o_result
);
    import kmp_pkg::*;

    logic    push;
    logic    full;
    t_cmd    front_cmd;
    logic    q_valid;
    logic    q_pop;
    t_cmd    q_cmd;
    logic    res_valid;
    t_report res;

    kmp_front #(
        .SLOT_COUNT       (SLOT_COUNT),
        .ACTIONS_PER_SLOT (ACTIONS_PER_SLOT)
    ) u_front (
        .i_item (i_item),
        .i_full (full),
        .o_push (push),
        .o_cmd  (front_cmd)
    );

    kmp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    kmp_back #(
        .SLOT_COUNT       (SLOT_COUNT),
        .ACTIONS_PER_SLOT (ACTIONS_PER_SLOT),
        .REPORT_KEYS      (REPORT_KEYS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_cmd),
        .o_cmd_pop     (q_pop),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .i_res_ready   (o_result.ready)
    );

    // Drive the report channel
    assign o_result.valid         = res_valid;
    assign o_result.modifier_bits = res.modifier_bits;
    assign o_result.key_a         = res.keys[0];
    assign o_result.key_b         = res.keys[1];
    assign o_result.key_c         = res.keys[2];
    assign o_result.key_d         = res.keys[3];
    assign o_result.key_e         = res.keys[4];
    assign o_result.key_f         = res.keys[5];
    assign o_result.running       = res.running;

endmodule

// ----- tb/sv/kmp_report_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// kmp_report_checker - report predictor and scoreboard of the macro player
// Watches the item, report and register ports, replays every accepted item
// on a private model of the player and compares each report in order.
// ============================================================================
module kmp_report_checker #(
    parameter int SLOT_COUNT       = kmp_pkg::DEF_SLOT_COUNT,
    parameter int ACTIONS_PER_SLOT = kmp_pkg::DEF_ACTIONS_PER_SLOT,
    parameter int REPORT_KEYS      = kmp_pkg::DEF_REPORT_KEYS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    kmp_item_if         i_item,
    kmp_report_if       i_report,
    output int          o_fail_count,
    output int          o_expect_count
);
    import kmp_pkg::*;

    localparam int         STORE_DEPTH   = SLOT_COUNT * ACTIONS_PER_SLOT;
    localparam int         SHOWN_LIMIT   = 10;
    localparam logic [7:0] KEY_LEFT_CTRL = 8'hE0;
    localparam logic [7:0] KEY_LEFT_GUI  = 8'hE3;

    // Model of the player
    logic [15:0] entry_mem [STORE_DEPTH];
    logic [6:0]  next_pos [SLOT_COUNT];
    logic [7:0]  held_keys [MAX_KEYS];
    int          held_count;
    logic [7:0]  mod_state;
    logic [2:0]  playing_slot;
    logic        press_pending;
    logic        delay_armed;
    logic [31:0] delay_start;
    logic [15:0] unit_ms;

    // Reports still owed by the player, oldest first
    t_report     expected_reports [$];
    int          mismatch_total = 0;

    function automatic logic [7:0] mod_bit(input logic [7:0] key);
        if (key >= KEY_LEFT_CTRL && key <= KEY_LEFT_GUI) begin
            return 8'h01 << (key - KEY_LEFT_CTRL);
        end
        return 8'h00;
    endfunction

    function automatic int key_index(input logic [7:0] key);
        for (int i = 0; i < held_count && i < REPORT_KEYS; i++) begin
            if (held_keys[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic clear_model();
        for (int i = 0; i < STORE_DEPTH; i++) entry_mem[i] = '0;
        for (int i = 0; i < SLOT_COUNT; i++) next_pos[i] = '0;
        for (int i = 0; i < MAX_KEYS; i++) held_keys[i] = KEY_NONE;
        held_count    = 0;
        mod_state     = 8'h00;
        playing_slot  = NO_SLOT;
        press_pending = 1'b0;
        delay_armed   = 1'b0;
        delay_start   = '0;
        unit_ms       = DELAY_UNIT_RESET;
        expected_reports.delete();
    endtask

    task automatic press_key(input logic [7:0] key);
        if (key != KEY_NONE && key_index(key) < 0 && held_count < REPORT_KEYS) begin
            held_keys[held_count] = key;
            held_count++;
        end
        mod_state |= mod_bit(key);
    endtask

    // Drop the key and move the last one into its place
    task automatic release_key(input logic [7:0] key);
        int at;
        at = (key != KEY_NONE) ? key_index(key) : -1;
        if (at >= 0 && held_count > 0) begin
            held_keys[at] = held_keys[held_count - 1];
            held_keys[held_count - 1] = KEY_NONE;
            held_count--;
        end
        mod_state &= ~mod_bit(key);
    endtask

    // Execute one action of the playing slot
    task automatic run_action(input logic [31:0] now);
        int          s;
        logic [6:0]  pos;
        logic [15:0] entry;
        logic [7:0]  code;
        logic [7:0]  value;
        logic        advance;
        logic [31:0] span;
        logic [31:0] wait_ms;
        if (int'(playing_slot) >= SLOT_COUNT) begin
            return;
        end
        s   = int'(playing_slot);
        pos = next_pos[s];
        if (int'(pos) >= ACTIONS_PER_SLOT) begin
            playing_slot = NO_SLOT;
            return;
        end
        entry   = entry_mem[s * ACTIONS_PER_SLOT + int'(pos)];
        code    = entry[15:8];
        value   = entry[7:0];
        advance = 1'b0;
        case (code)
            ACT_DOWN: begin
                press_key(value);
                advance = 1'b1;
            end
            ACT_UP: begin
                release_key(value);
                advance = 1'b1;
            end
            ACT_PRESS: begin
                if (press_pending) begin
                    release_key(value);
                    press_pending = 1'b0;
                    advance = 1'b1;
                end else begin
                    press_key(value);
                    press_pending = 1'b1;
                end
            end
            ACT_DELAY: begin
                span    = now - delay_start;
                wait_ms = {24'h000000, value} * {16'h0000, unit_ms};
                if (!delay_armed) begin
                    delay_armed = 1'b1;
                    delay_start = now;
                end else if (span > wait_ms) begin
                    delay_armed = 1'b0;
                    advance = 1'b1;
                end
            end
            default: begin
                advance = 1'b1;
            end
        endcase
        if (advance) begin
            pos = pos + 7'd1;
        end
        next_pos[s] = pos;
        if (code == ACT_END || code == ACT_PAUSE || int'(pos) >= ACTIONS_PER_SLOT) begin
            playing_slot = NO_SLOT;
        end
    endtask

    // Queue the report that the current state gives
    task automatic push_report();
        t_report r;
        r.modifier_bits = mod_state;
        for (int i = 0; i < MAX_KEYS; i++) begin
            r.keys[i] = (i < REPORT_KEYS && i < held_count) ? held_keys[i] : KEY_NONE;
        end
        r.running = (playing_slot != NO_SLOT);
        expected_reports.push_back(r);
    endtask

    task automatic predict_item();
        logic [2:0] slot;
        slot = i_item.slot;
        case (i_item.kind)
            KIND_LOAD: begin
                if (int'(slot) < SLOT_COUNT && int'(i_item.position) < ACTIONS_PER_SLOT) begin
                    entry_mem[int'(slot) * ACTIONS_PER_SLOT + int'(i_item.position)] =
                        {i_item.action_code, i_item.action_value};
                end
            end
            KIND_STEP: begin
                if (playing_slot != NO_SLOT) begin
                    run_action(i_item.now_ms);
                    push_report();
                end
            end
            default: begin
                // Start or resume only from idle and on a real slot
                if (playing_slot == NO_SLOT && int'(slot) < SLOT_COUNT && slot != NO_SLOT) begin
                    if (i_item.kind == KIND_START) begin
                        next_pos[slot] = '0;
                    end
                    playing_slot = slot;
                    run_action(i_item.now_ms);
                    push_report();
                end
            end
        endcase
    endtask

    task automatic check_report();
        t_report got;
        t_report want;
        logic    bad;
        got.modifier_bits = i_report.modifier_bits;
        got.keys[0]       = i_report.key_a;
        got.keys[1]       = i_report.key_b;
        got.keys[2]       = i_report.key_c;
        got.keys[3]       = i_report.key_d;
        got.keys[4]       = i_report.key_e;
        got.keys[5]       = i_report.key_f;
        got.running       = i_report.running;
        if (expected_reports.size() == 0) begin
            if (mismatch_total < SHOWN_LIMIT) begin
                $display("unexpected report: mod=%02h keys=%02h %02h %02h %02h %02h %02h run=%0b",
                         got.modifier_bits, got.keys[0], got.keys[1], got.keys[2],
                         got.keys[3], got.keys[4], got.keys[5], got.running);
            end
            mismatch_total++;
            return;
        end
        want = expected_reports.pop_front();
        bad  = (got.modifier_bits !== want.modifier_bits) || (got.running !== want.running);
        for (int i = 0; i < MAX_KEYS; i++) begin
            bad = bad || (got.keys[i] !== want.keys[i]);
        end
        if (bad) begin
            if (mismatch_total < SHOWN_LIMIT) begin
                $display("report mismatch at %0t", $realtime);
                $display("  expected mod=%02h keys=%02h %02h %02h %02h %02h %02h run=%0b",
                         want.modifier_bits, want.keys[0], want.keys[1], want.keys[2],
                         want.keys[3], want.keys[4], want.keys[5], want.running);
                $display("  actual   mod=%02h keys=%02h %02h %02h %02h %02h %02h run=%0b",
                         got.modifier_bits, got.keys[0], got.keys[1], got.keys[2],
                         got.keys[3], got.keys[4], got.keys[5], got.running);
            end
            mismatch_total++;
        end
    endtask

    // Retire the report before the item of the same edge can add one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_cfg_wr_en) begin
                unit_ms = i_cfg_wr_data;
            end
            if (i_report.valid && i_report.ready) begin
                check_report();
            end
            if (i_item.valid && i_item.ready) begin
                predict_item();
            end
        end
        o_expect_count = expected_reports.size();
        o_fail_count   = mismatch_total;
    end

endmodule

// ----- tb/sv/tb_keyboard_macro_player_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_keyboard_macro_player_unit - testbench of the keyboard macro player
// Fills every action store, runs directed macros over the corner cases, then
// random macros with noise under several delay units, with random stalls on
// both channels. A separate checker predicts and compares every report.
// ============================================================================
module tb_keyboard_macro_player_unit;
    import kmp_pkg::*;

    localparam int SLOT_COUNT       = DEF_SLOT_COUNT;
    localparam int ACTIONS_PER_SLOT = DEF_ACTIONS_PER_SLOT;
    localparam int REPORT_KEYS      = DEF_REPORT_KEYS;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 3;
    localparam int IDLE_PERCENT  = 29;
    localparam int NOISE_PERCENT = 8;
    localparam int PHASE_ITEMS   = 200;
    localparam int PHASE_COUNT   = 4;
    localparam int DRAIN_CYCLES  = 2 * QUEUE_DEPTH + 8;
    localparam int STALL_LIMIT   = 2000;

    localparam logic [7:0] KEY_FIRST = 8'h04;
    localparam logic [7:0] MOD_FIRST = 8'hE0;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        take_report = 1'b0;
    bit          steady      = 1'b0;
    logic [31:0] sim_ms      = '0;
    int          sent_items  = 0;
    int          quiet_cycles = 0;
    int          fail_count;
    int          expect_count;

    kmp_item_if   item_ch ();
    kmp_report_if report_ch ();

    assign report_ch.ready = take_report;

    keyboard_macro_player_unit #(
        .SLOT_COUNT       (SLOT_COUNT),
        .ACTIONS_PER_SLOT (ACTIONS_PER_SLOT),
        .REPORT_KEYS      (REPORT_KEYS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_item        (item_ch),
        .o_result      (report_ch)
    );

    kmp_report_checker #(
        .SLOT_COUNT       (SLOT_COUNT),
        .ACTIONS_PER_SLOT (ACTIONS_PER_SLOT),
        .REPORT_KEYS      (REPORT_KEYS)
    ) report_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_item         (item_ch),
        .i_report       (report_ch),
        .o_fail_count   (fail_count),
        .o_expect_count (expect_count)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Stall the report side at random
    always @(negedge i_clk) begin
        take_report <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready)
                || (report_ch.valid && report_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Advance the millisecond clock, mostly a little, now and then anywhere
    function automatic logic [31:0] wander_ms();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            sim_ms = sim_ms + $urandom_range(0, 400);
        end else if (r < 95) begin
            sim_ms = sim_ms + $urandom_range(0, 1 << 20);
        end else begin
            sim_ms = $urandom;
        end
        return sim_ms;
    endfunction

    // Keys from a small pool so that ups hit and the set fills
    function automatic logic [7:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return KEY_FIRST + 8'($urandom_range(0, 7));
        if (r < 90) return MOD_FIRST + 8'($urandom_range(0, 3));
        if (r < 95) return KEY_NONE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] random_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return {ACT_DOWN, pick_key()};
        if (r < 55) return {ACT_UP, pick_key()};
        if (r < 70) return {ACT_PRESS, pick_key()};
        if (r < 78) return {ACT_DELAY, 8'($urandom_range(0, 3))};
        if (r < 80) return {ACT_DELAY, 8'($urandom_range(0, 255))};
        if (r < 83) return {ACT_PAUSE, 8'($urandom_range(0, 255))};
        if (r < 90) return {8'($urandom_range(ACT_PAUSE + 1, 255)), 8'($urandom_range(0, 255))};
        return {(r < 95) ? ACT_DOWN : ACT_UP, 8'($urandom_range(0, 255))};
    endfunction

    // Present one item after a random gap and hold it until taken
    task automatic send_item(input logic [1:0] kind, input logic [2:0] slot,
                             input logic [5:0] position, input logic [7:0] code,
                             input logic [7:0] value, input logic [31:0] now);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            item_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid        = 1'b1;
        item_ch.kind         = kind;
        item_ch.slot         = slot;
        item_ch.position     = position;
        item_ch.action_code  = code;
        item_ch.action_value = value;
        item_ch.now_ms       = now;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic load_entry(input int slot, input int position,
                              input logic [7:0] code, input logic [7:0] value);
        send_item(KIND_LOAD, 3'(slot), 6'(position), code, value, sim_ms);
    endtask

    task automatic kick(input logic [1:0] kind, input int slot, input logic [31:0] now);
        send_item(kind, 3'(slot), 6'($urandom), 8'($urandom), 8'($urandom), now);
    endtask

    task automatic step_at(input logic [31:0] now);
        sim_ms = now;
        kick(KIND_STEP, $urandom_range(0, 7), now);
    endtask

    task automatic send_noise();
        if ($urandom_range(0, 99) < NOISE_PERCENT) begin
            send_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                      6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), wander_ms());
        end
    endtask

    // Hold off the sender until every report has come
    task automatic drain(input int extra);
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        while (expect_count != 0) @(negedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    initial begin
        int          n;
        int          steps;
        int          slot_sel;
        int          goal;
        logic [15:0] act;
        logic [15:0] units [PHASE_COUNT];

        item_ch.valid        = 1'b0;
        item_ch.kind         = KIND_LOAD;
        item_ch.slot         = '0;
        item_ch.position     = '0;
        item_ch.action_code  = ACT_END;
        item_ch.action_value = '0;
        item_ch.now_ms       = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Write every entry: ends everywhere, skipped codes in the last slot
        for (int s = 0; s < SLOT_COUNT; s++) begin
            for (int p = 0; p < ACTIONS_PER_SLOT; p++) begin
                load_entry(s, p, (s == SLOT_COUNT - 1) ?
                           8'($urandom_range(ACT_PAUSE + 1, 255)) : ACT_END,
                           8'($urandom_range(0, 255)));
            end
        end

        // Loads to slots past the last one are dropped
        load_entry(SLOT_COUNT + 1, 0, ACT_DOWN, KEY_FIRST);
        load_entry(NO_SLOT, ACTIONS_PER_SLOT - 1, ACT_DOWN, KEY_FIRST);

        // Slot 0: every action, key zero, release of an absent key
        load_entry(0, 0, ACT_DOWN, 8'hE1);
        load_entry(0, 1, ACT_DOWN, 8'h04);
        load_entry(0, 2, ACT_PRESS, 8'h05);
        load_entry(0, 3, ACT_DELAY, 8'd1);
        load_entry(0, 4, ACT_DOWN, KEY_NONE);
        load_entry(0, 5, ACT_UP, KEY_NONE);
        load_entry(0, 6, ACT_UP, 8'h06);
        load_entry(0, 7, ACT_UP, 8'h04);
        load_entry(0, 8, ACT_PAUSE, 8'h00);
        load_entry(0, 9, ACT_UP, 8'hE1);
        load_entry(0, 10, ACT_END, 8'h00);
        step_at(900);
        kick(KIND_START, 0, 1000);
        kick(KIND_START, 1, 1000);
        step_at(1010);
        step_at(1020);
        step_at(1030);
        step_at(2000);
        step_at(2050);
        step_at(2101);
        step_at(2110);
        step_at(2120);
        step_at(2130);
        step_at(2140);
        step_at(2150);
        kick(KIND_START, SLOT_COUNT, 2200);
        kick(KIND_START, NO_SLOT, 2200);
        kick(KIND_RESUME, SLOT_COUNT + 1, 2200);
        kick(KIND_RESUME, 0, 3000);
        step_at(3010);

        // Slot 1: overfill the key set, a modifier past the limit
        for (int i = 0; i < REPORT_KEYS + 1; i++) begin
            load_entry(1, i, ACT_DOWN, KEY_FIRST + 8'(i));
        end
        load_entry(1, REPORT_KEYS + 1, ACT_DOWN, 8'hE2);
        kick(KIND_START, 1, 4000);
        repeat (REPORT_KEYS + 2) step_at(sim_ms + 1);

        // Last slot: run to the end of the store, then resume it
        kick(KIND_START, SLOT_COUNT - 1, 5000);
        repeat (ACTIONS_PER_SLOT) step_at(sim_ms + 1);
        kick(KIND_RESUME, SLOT_COUNT - 1, 6000);

        units[0] = 16'd1;
        units[1] = 16'hFFFF;
        units[2] = 16'($urandom_range(2, 65534));
        units[3] = DELAY_UNIT_RESET;

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            drain(DRAIN_CYCLES);
            @(negedge i_clk);
            cfg_wr_en   = 1'b1;
            cfg_wr_data = units[ph];
            @(negedge i_clk);
            cfg_wr_en = 1'b0;
            steady    = (ph == 1);
            goal      = sent_items + PHASE_ITEMS;

            // Write a short macro, play it, step it out, with noise between
            while (sent_items < goal) begin
                slot_sel = $urandom_range(0, SLOT_COUNT - 1);
                n        = $urandom_range(1, 10);
                for (int i = 0; i < n; i++) begin
                    send_noise();
                    act = random_action();
                    load_entry(slot_sel, i, act[15:8], act[7:0]);
                end
                load_entry(slot_sel, n, ($urandom_range(0, 99) < 80) ? ACT_END : ACT_PAUSE,
                           8'($urandom_range(0, 255)));
                kick(($urandom_range(0, 99) < 85) ? KIND_START : KIND_RESUME, slot_sel,
                     wander_ms());
                steps = 2 * n + $urandom_range(0, 3);
                repeat (steps) begin
                    send_noise();
                    step_at(wander_ms());
                end
                if ($urandom_range(0, 19) == 0) begin
                    drain(0);
                end
            end
        end
        steady = 1'b0;

        drain(DRAIN_CYCLES);
        @(negedge i_clk);
        if (fail_count == 0 && expect_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
